/* rtl/gsde_pkg.sv */
// gsde_pkg: shared types and constants of the differential gas sensor front end
// used by every module of the block; depends on nothing

package gsde_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int COUNT_W     = 8;
   localparam int ACC_W       = SAMPLE_BITS + COUNT_W;
   localparam int DIV_CNT_W   = $clog2(ACC_W + 1);
   localparam int MV_W        = 11;
   localparam int MVX_W       = SAMPLE_BITS + MV_W;
   localparam int PPM_W       = 32;
   localparam int ALPHA_W     = 17;
   localparam int ALPHA_FRAC  = 16;
   localparam int SUM_W       = PPM_W + ALPHA_FRAC;
   localparam int MUL_A_W     = 32;
   localparam int MUL_B_W     = 17;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;

   localparam int MV_FULL     = 1250;
   localparam int FULL_SCALE  = (1 << SAMPLE_BITS) - 1;
   // (2^S + 1) * (2^S - 1) = 2^2S - 1, so x * RECIP >> 2S is floor(x / FULL_SCALE) or one less
   localparam int RECIP       = FULL_SCALE + 2;
   localparam int RECIP_SHIFT = 2 * SAMPLE_BITS;
   localparam int ALPHA_ONE   = 1 << ALPHA_FRAC;

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLES_PER_GROUP = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PPM_GAIN          = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_ALPHA   = 2'd2;

   localparam logic [COUNT_W-1:0] SPG_RESET  = 8'd1;
   localparam logic [PPM_W-1:0]   GAIN_RESET = 32'd65536;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] vout_sample;
      logic [SAMPLE_BITS-1:0] vref_sample;
      logic                   sample_error;
   } gsde_req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] vout_raw_avg;
      logic [SAMPLE_BITS-1:0] vref_raw_avg;
      logic [MV_W-1:0]        vout_mv;
      logic [MV_W-1:0]        vref_mv;
      logic [PPM_W-1:0]       co_ppm;
      logic                   data_valid;
   } gsde_rsp_type;

endpackage

/* rtl/gsde_div.sv */
// gsde_div: restoring divider, one quotient bit per cycle
// divides a channel sum by the group size; uses gsde_pkg

module gsde_div
   import gsde_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [ACC_W-1:0]   dividend,
   input  logic [COUNT_W-1:0] divisor,
   output logic               done,
   output logic [ACC_W-1:0]   quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ACC_W-1:0]     quo_ff, quo_in;
   logic [COUNT_W-1:0]   rem_ff, rem_in;
   logic [COUNT_W-1:0]   dsr_ff, dsr_in;
   logic [COUNT_W:0]     shifted;
   logic [COUNT_W:0]     diff;
   logic                 ge;

   assign shifted = {rem_ff, quo_ff[ACC_W-1]};
   assign ge      = shifted >= {1'b0, dsr_ff};
   assign diff    = shifted - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(ACC_W);
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[ACC_W-2:0], ge};
         rem_in = ge ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/gsde_mul.sv */
// gsde_mul: shared 32 x 17 multiplier with registered product
// serves millivolt scaling, gain and smoothing steps; uses gsde_pkg

module gsde_mul
   import gsde_pkg::*;
(
   input  logic               clock,
   input  logic [MUL_A_W-1:0] op_a,
   input  logic [MUL_B_W-1:0] op_b,
   output logic [PROD_W-1:0]  prod
);

   logic [PROD_W-1:0] prod_ff, prod_in;

   assign prod_in = {{MUL_B_W{1'b0}}, op_a} * {{MUL_A_W{1'b0}}, op_b};

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

/* rtl/gas_sensor_differential_ema.sv */
// Differential gas sensor front end: sums paired output and reference counts over a group,
// then averages, converts to millivolts, scales to Q16.16 ppm and smooths. A pair that does
// not close a group is added to the sums without holding the input off. A pair that closes
// a group holds the input off until its result reaches the output register; smoothing is
// skipped when off or not yet seeded. The two 20-step divisions of the channel sums by the
// group size run in gsde_div, each started in S_DIV_GO and awaited in S_DIV_WAIT. The rest
// run one after another through the single gsde_mul multiplier: millivolt conversion in
// S_MV1 to S_MV4 per channel, the gain product in S_PPM1 and S_PPM2, smoothing in S_EMA1
// and S_EMA2, then S_OUT loads the output register. The result sits there and new pairs are
// taken meanwhile; a later group waits in S_OUT until the register is free. A failed-read
// group goes straight to S_OUT with data_valid low. Uses gsde_pkg, gsde_div and gsde_mul.

module gas_sensor_differential_ema
   import gsde_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gsde_req_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gsde_rsp_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV_GO,
      S_DIV_WAIT,
      S_MV1,
      S_MV2,
      S_MV3,
      S_MV4,
      S_PPM1,
      S_PPM2,
      S_EMA1,
      S_EMA2,
      S_OUT
   } state_type;

   // configuration
   logic [COUNT_W-1:0] spg_ff, spg_in;
   logic [PPM_W-1:0]   gain_ff, gain_in;
   logic [ALPHA_W-1:0] alpha_ff, alpha_in;

   // sequencer and working registers
   state_type              state_ff, state_in;
   logic                   ch_ff, ch_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [ACC_W-1:0]       vout_acc_ff, vout_acc_in;
   logic [ACC_W-1:0]       vref_acc_ff, vref_acc_in;
   logic                   gerr_ff, gerr_in;
   logic [PPM_W-1:0]       smoothed_ff, smoothed_in;
   logic                   seeded_ff, seeded_in;
   logic [SAMPLE_BITS-1:0] avg_o_ff, avg_o_in;
   logic [SAMPLE_BITS-1:0] avg_r_ff, avg_r_in;
   logic [MV_W-1:0]        mv_o_ff, mv_o_in;
   logic [MV_W-1:0]        mv_r_ff, mv_r_in;
   logic [MVX_W-1:0]       x_ff, x_in;
   logic [MV_W-1:0]        q_ff, q_in;
   logic [PPM_W-1:0]       p_ff, p_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   dv_ff, dv_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   gsde_rsp_type           rsp_data_ff, rsp_data_in;

   logic                   req_fire;
   logic [COUNT_W-1:0]     n_eff;
   logic [COUNT_W-1:0]     count_next;
   logic [ACC_W-1:0]       vout_sum, vref_sum;
   logic [ALPHA_W-1:0]     a_eff;
   logic [MVX_W-1:0]       mv_rem;
   logic [MV_W-1:0]        mv_fix;
   logic [SUM_W-1:0]       ema_sum;

   logic                   div_start;
   logic [ACC_W-1:0]       div_dividend;
   logic                   div_done;
   logic [ACC_W-1:0]       div_quotient;
   logic [MUL_A_W-1:0]     mul_a;
   logic [MUL_B_W-1:0]     mul_b;
   logic [PROD_W-1:0]      prod;

   gsde_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   gsde_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      spg_in   = spg_ff;
      gain_in  = gain_ff;
      alpha_in = alpha_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SAMPLES_PER_GROUP: spg_in   = csr_data[COUNT_W-1:0];
            CSR_PPM_GAIN:          gain_in  = csr_data[PPM_W-1:0];
            CSR_SMOOTHING_ALPHA:   alpha_in = csr_data[ALPHA_W-1:0];
            default:               spg_in   = spg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spg_ff   <= SPG_RESET;
         gain_ff  <= GAIN_RESET;
         alpha_ff <= '0;
      end else begin
         spg_ff   <= spg_in;
         gain_ff  <= gain_in;
         alpha_ff <= alpha_in;
      end
   end

   // datapath helpers
   assign req_stall  = (state_ff != S_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign n_eff      = (spg_ff == '0) ? COUNT_W'(1) : spg_ff;
   assign count_next = count_ff + 1'b1;
   assign vout_sum   = vout_acc_ff + ACC_W'(req_data.vout_sample);
   assign vref_sum   = vref_acc_ff + ACC_W'(req_data.vref_sample);
   assign a_eff      = (alpha_ff > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : alpha_ff;
   assign mv_rem     = x_ff - prod[MVX_W-1:0];
   assign mv_fix     = q_ff + MV_W'(mv_rem >= MVX_W'(FULL_SCALE));
   assign ema_sum    = sum_ff + prod[SUM_W-1:0];

   assign div_start    = (state_ff == S_DIV_GO);
   assign div_dividend = ch_ff ? vref_acc_ff : vout_acc_ff;

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MV1: begin
            mul_a = MUL_A_W'(ch_ff ? avg_r_ff : avg_o_ff);
            mul_b = MUL_B_W'(MV_FULL);
         end
         S_MV2: begin
            mul_a = MUL_A_W'(prod[MVX_W-1:0]);
            mul_b = MUL_B_W'(RECIP);
         end
         S_MV3: begin
            mul_a = MUL_A_W'(prod[RECIP_SHIFT +: MV_W]);
            mul_b = MUL_B_W'(FULL_SCALE);
         end
         S_PPM1: begin
            mul_a = gain_ff;
            mul_b = (mv_o_ff > mv_r_ff) ? MUL_B_W'(mv_o_ff - mv_r_ff) : '0;
         end
         S_PPM2: begin
            mul_a = smoothed_ff;
            mul_b = MUL_B_W'(ALPHA_ONE) - MUL_B_W'(a_eff);
         end
         S_EMA1: begin
            mul_a = p_ff;
            mul_b = MUL_B_W'(a_eff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      count_in     = count_ff;
      vout_acc_in  = vout_acc_ff;
      vref_acc_in  = vref_acc_ff;
      gerr_in      = gerr_ff;
      smoothed_in  = smoothed_ff;
      seeded_in    = seeded_ff;
      avg_o_in     = avg_o_ff;
      avg_r_in     = avg_r_ff;
      mv_o_in      = mv_o_ff;
      mv_r_in      = mv_r_ff;
      x_in         = x_ff;
      q_in         = q_ff;
      p_in         = p_ff;
      sum_in       = sum_ff;
      dv_in        = dv_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (count_next >= n_eff) begin
                  if (gerr_ff || req_data.sample_error) begin
                     avg_o_in    = '0;
                     avg_r_in    = '0;
                     mv_o_in     = '0;
                     mv_r_in     = '0;
                     dv_in       = 1'b0;
                     count_in    = '0;
                     vout_acc_in = '0;
                     vref_acc_in = '0;
                     gerr_in     = 1'b0;
                     state_in    = S_OUT;
                  end else begin
                     count_in    = count_next;
                     vout_acc_in = vout_sum;
                     vref_acc_in = vref_sum;
                     ch_in       = 1'b0;
                     state_in    = S_DIV_GO;
                  end
               end else begin
                  count_in    = count_next;
                  vout_acc_in = vout_sum;
                  vref_acc_in = vref_sum;
                  gerr_in     = gerr_ff || req_data.sample_error;
               end
            end
         end
         S_DIV_GO: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               if (ch_ff) begin
                  avg_r_in    = div_quotient[SAMPLE_BITS-1:0];
                  count_in    = '0;
                  vout_acc_in = '0;
                  vref_acc_in = '0;
                  gerr_in     = 1'b0;
                  ch_in       = 1'b0;
                  state_in    = S_MV1;
               end else begin
                  avg_o_in = div_quotient[SAMPLE_BITS-1:0];
                  ch_in    = 1'b1;
                  state_in = S_DIV_GO;
               end
            end
         end
         S_MV1: begin
            state_in = S_MV2;
         end
         S_MV2: begin
            x_in     = prod[MVX_W-1:0];
            state_in = S_MV3;
         end
         S_MV3: begin
            q_in     = prod[RECIP_SHIFT +: MV_W];
            state_in = S_MV4;
         end
         S_MV4: begin
            if (ch_ff) begin
               mv_r_in  = mv_fix;
               ch_in    = 1'b0;
               state_in = S_PPM1;
            end else begin
               mv_o_in  = mv_fix;
               ch_in    = 1'b1;
               state_in = S_MV1;
            end
         end
         S_PPM1: begin
            state_in = S_PPM2;
         end
         S_PPM2: begin
            p_in  = (|prod[PROD_W-1:PPM_W]) ? '1 : prod[PPM_W-1:0];
            dv_in = 1'b1;
            if ((a_eff != '0) && seeded_ff) begin
               state_in = S_EMA1;
            end else begin
               smoothed_in = (|prod[PROD_W-1:PPM_W]) ? '1 : prod[PPM_W-1:0];
               seeded_in   = 1'b1;
               state_in    = S_OUT;
            end
         end
         S_EMA1: begin
            sum_in   = prod[SUM_W-1:0];
            state_in = S_EMA2;
         end
         S_EMA2: begin
            smoothed_in = ema_sum[ALPHA_FRAC +: PPM_W];
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.vout_raw_avg = avg_o_ff;
               rsp_data_in.vref_raw_avg = avg_r_ff;
               rsp_data_in.vout_mv      = mv_o_ff;
               rsp_data_in.vref_mv      = mv_r_ff;
               rsp_data_in.co_ppm       = smoothed_ff;
               rsp_data_in.data_valid   = dv_ff;
               state_in                 = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= 1'b0;
         count_ff     <= '0;
         vout_acc_ff  <= '0;
         vref_acc_ff  <= '0;
         gerr_ff      <= 1'b0;
         smoothed_ff  <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         count_ff     <= count_in;
         vout_acc_ff  <= vout_acc_in;
         vref_acc_ff  <= vref_acc_in;
         gerr_ff      <= gerr_in;
         smoothed_ff  <= smoothed_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      avg_o_ff    <= avg_o_in;
      avg_r_ff    <= avg_r_in;
      mv_o_ff     <= mv_o_in;
      mv_r_ff     <= mv_r_in;
      x_ff        <= x_in;
      q_ff        <= q_in;
      p_ff        <= p_in;
      sum_ff      <= sum_in;
      dv_ff       <= dv_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/gsde_checker.sv */
// gsde_checker: port-level assertions for the gas sensor front end, bound to the top level
// uses gsde_pkg; attaches to gas_sensor_differential_ema

module gsde_checker
   import gsde_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input gsde_rsp_type rsp_data
);

   // a stalled transaction stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled transaction keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("rsp_data changed while stalled");

   // a group with a failed read reports no averages
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.data_valid |->
         rsp_data.vout_raw_avg == '0 && rsp_data.vref_raw_avg == '0 &&
         rsp_data.vout_mv == '0 && rsp_data.vref_mv == '0)
      else $error("error group carries nonzero averages");

   // millivolt conversion keeps the order of the averages
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.data_valid &&
      rsp_data.vout_raw_avg >= rsp_data.vref_raw_avg |->
         rsp_data.vout_mv >= rsp_data.vref_mv)
      else $error("millivolt order differs from count order");

endmodule

bind gas_sensor_differential_ema gsde_checker u_gsde_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
